@@ rtl/core/catan_pkg.sv @@
// Package for the CORDIC atan2 block: datapath widths and the arctangent table.
// No dependencies; used by cordic_atan2_degrees_top and its checker.
`timescale 1ns / 1ps

package catan_pkg;

	localparam int IN_W  = 15;	// input coordinate width
	localparam int XY_W  = 18;	// rotated vector width, holds growth of |x| and |y|
	localparam int SUM_W = 18;	// accumulated angle, at most 99435 in magnitude
	localparam int ANG_W = 19;	// result angle width
	localparam int EXT_W = 20;	// width used for the quadrant correction

	localparam int MAX_STEPS = 8;

	typedef logic signed [IN_W-1:0]  coord_t;
	typedef logic signed [XY_W-1:0]  vec_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [ANG_W-1:0] angle_t;
	typedef logic signed [EXT_W-1:0] ext_t;

	localparam ext_t HALF_TURN = 20'sd180000;

	// Arctangent of 2^-i in millidegrees.
	localparam sum_t ATAN_TABLE [MAX_STEPS] = '{
		18'sd45000, 18'sd26565, 18'sd14036, 18'sd7125,
		18'sd3576,  18'sd1790,  18'sd895,   18'sd448
	};

endpackage

@@ rtl/core/cordic_atan2_degrees_top.sv @@
// CORDIC vectoring atan2 returning the angle in millidegrees.
// Depends on catan_pkg for widths and the arctangent table.
//
//  channel  | ports                        | handshake
//  ---------+------------------------------+---------------------------------
//  command  | x_milli, y_milli             | beat taken when start && !busy
//  result   | angle_millideg               | one-cycle beat marked by done
//
// Each vector passes an input register and a result register, and done is
// the valid flag of the result register, so there is one result beat for
// every command beat.
// A new vector is taken every cycle; busy stays low as the iterations are
// unrolled between the two registers and hold no state between vectors.
// arst_n clears both valid flags; there is no result stall, so the receiver must
// take every result in the cycle it is shown; the block does not enforce this.
`timescale 1ns / 1ps

module cordic_atan2_degrees_top #(
	parameter int ITERATIONS = 7
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  catan_pkg::coord_t            x_milli,
	input  catan_pkg::coord_t            y_milli,
	output logic                         done,
	output catan_pkg::angle_t            angle_millideg
);

	localparam int STEPS = (ITERATIONS > catan_pkg::MAX_STEPS) ?
		catan_pkg::MAX_STEPS : ITERATIONS;

	logic              valid_s1;
	catan_pkg::coord_t x_s1;
	catan_pkg::coord_t y_s1;
	logic              valid_s2;
	catan_pkg::angle_t angle_s2;

	catan_pkg::sum_t   sum_c;
	catan_pkg::ext_t   angle_c;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			x_s1 <= x_milli;
			y_s1 <= y_milli;
		end
		if (valid_s1) begin
			angle_s2 <= angle_c[catan_pkg::ANG_W-1:0];
		end
	end

	// Vectoring iterations on the absolute values; once y reaches zero the
	// remaining steps leave both the vector and the sum untouched.
	always_comb begin
		catan_pkg::vec_t x;
		catan_pkg::vec_t y;
		catan_pkg::vec_t xn;
		catan_pkg::vec_t yn;
		logic            stopped;
		x = catan_pkg::vec_t'(x_s1);
		y = catan_pkg::vec_t'(y_s1);
		if (x < 0) x = -x;
		if (y < 0) y = -y;
		sum_c   = '0;
		stopped = 1'b0;
		for (int i = 0; i < STEPS; i++) begin
			xn = x;
			yn = y;
			if (y == 0) begin
				stopped = 1'b1;
			end
			if (!stopped) begin
				if (y > 0) begin
					xn    = x + (y >>> i);
					yn    = y - (x >>> i);
					sum_c = sum_c + catan_pkg::ATAN_TABLE[3'(i)];
				end else begin
					xn    = x - (y >>> i);
					yn    = y + (x >>> i);
					sum_c = sum_c - catan_pkg::ATAN_TABLE[3'(i)];
				end
			end
			x = xn;
			y = yn;
		end
	end

	// Quadrant correction from the signs of the original coordinates.
	always_comb begin
		catan_pkg::ext_t s;
		s = catan_pkg::ext_t'(sum_c);
		unique case ({x_s1[catan_pkg::IN_W-1], y_s1[catan_pkg::IN_W-1]})
			2'b00:   angle_c = s;
			2'b01:   angle_c = -s;
			2'b10:   angle_c = catan_pkg::HALF_TURN - s;
			default: angle_c = s - catan_pkg::HALF_TURN;
		endcase
	end

	assign done           = valid_s2;
	assign angle_millideg = angle_s2;

endmodule

@@ rtl/core/catan_checker.sv @@
// Port-level checker for cordic_atan2_degrees_top, attached by bind.
// Depends on catan_pkg for the port types.
`timescale 1ns / 1ps

module catan_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input catan_pkg::coord_t x_milli,
	input catan_pkg::coord_t y_milli,
	input logic              done,
	input catan_pkg::angle_t angle_millideg
);

	logic accept;
	assign accept = start && !busy;

	// Every command beat yields exactly one result beat, and done is never raised without one.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, 2) |-> (done == $past(accept, 2)))
		else $error("result beat does not match command beat two cycles earlier");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised although a vector is taken every cycle");

	a_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && x_milli == 0 && y_milli == 0) |-> ##2 (angle_millideg == 0))
		else $error("zero vector did not give a zero angle");

	a_negative_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && x_milli < 0 && y_milli == 0) |-> ##2 (angle_millideg == 19'sd180000))
		else $error("vector on the negative x axis did not give a half turn");

endmodule

bind cordic_atan2_degrees_top catan_checker u_catan_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.x_milli        (x_milli),
	.y_milli        (y_milli),
	.done           (done),
	.angle_millideg (angle_millideg)
);
